[src/bpp_pkg.sv]
// ---------------------------------------------------------------------------
// bpp_pkg: shared types and constants for the primary block parser
// Byte classification, queue entry, result record and decode codes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpp_pkg;

	localparam logic [7:0] VERSION_BPV6 = 8'd6;
	localparam logic [4:0] BASE_FIELDS  = 5'd14;
	localparam logic [4:0] FRAG_FIELDS  = 5'd2;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_PARSE
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_BADVER = 3'd1,
		ST_DICT   = 3'd2,
		ST_TRUNC  = 3'd3,
		ST_OVF    = 3'd4
	} status_t;

	// one classified input beat
	typedef struct packed {
		logic       first;
		logic       fin;
		logic       cont;
		logic       ver_ok;
		logic [6:0] low;
	} item_t;

	typedef struct packed {
		logic [3:0]  idx;
		logic [63:0] value;
		logic        valid;
		logic        done;
		status_t     status;
		logic [7:0]  used;
	} result_t;

endpackage

[src/bundle_primary_block_parser.sv]
// A byte beat is written into the queue when it is accepted and decoded when it reaches the
// queue head; its result is registered in res_q and offered on m_axis.
// Throughput: one byte per cycle while the output is not stalled, set by the single-byte SDNV shift into the decoder.
// A four-entry queue between classifier and decoder absorbs output stalls.
// Reset (arst_n low, asynchronous): queue empty, parser idle, no result pending.
// ---------------------------------------------------------------------------
// bundle_primary_block_parser: bundle primary block field decoder
// Decodes the version byte and the SDNV fields of a primary block, one byte a beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bundle_primary_block_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] first
	input  logic        s_axis_tlast,   // final_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,   // [3:0] field_index, [67:4] field_value,
	                                    // [70:68] status, [78:71] bytes_used, [79] zero
	output logic        m_axis_tuser,   // [0] field_valid
	output logic        m_axis_tlast    // done_res
);

	logic            q_ready;
	logic            q_push;
	bpp_pkg::item_t  push_item;
	logic            q_valid;
	bpp_pkg::item_t  q_item;
	logic            pop;

	bpp_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.q_ready       (q_ready),
		.q_push        (q_push),
		.q_item        (push_item)
	);

	bpp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.ready     (q_ready),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.pop       (pop)
	);

	bpp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

[src/bpp_front.sv]
// ---------------------------------------------------------------------------
// bpp_front: input side of the primary block parser
// Takes byte beats and classifies them for the decode queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpp_front (
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	input  logic [7:0]      s_axis_tdata,   // [7:0] data_byte
	input  logic            s_axis_tuser,   // [0] first
	input  logic            s_axis_tlast,   // final_byte
	input  logic            q_ready,
	output logic            q_push,
	output bpp_pkg::item_t  q_item
);

	assign s_axis_tready = q_ready;
	assign q_push        = s_axis_tvalid && q_ready;

	always_comb begin
		q_item.first  = s_axis_tuser;
		q_item.fin    = s_axis_tlast;
		q_item.cont   = s_axis_tdata[7];
		q_item.ver_ok = (s_axis_tdata == bpp_pkg::VERSION_BPV6);
		q_item.low    = s_axis_tdata[6:0];
	end

endmodule

[src/bpp_queue.sv]
// ---------------------------------------------------------------------------
// bpp_queue: short queue between classifier and decoder
// Lets the input side keep taking beats while the decoder stalls.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bpp_pkg::item_t  push_item,
	output logic            ready,
	output logic            q_valid,
	output bpp_pkg::item_t  q_item,
	input  logic            pop
);

	bpp_pkg::item_t                mem_q [bpp_pkg::Q_DEPTH];
	logic [bpp_pkg::Q_AW-1:0]      wptr_q;
	logic [bpp_pkg::Q_AW-1:0]      rptr_q;
	logic [bpp_pkg::Q_CW-1:0]      count_q;

	assign ready   = (count_q != bpp_pkg::Q_CW'(bpp_pkg::Q_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_item  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= bpp_pkg::Q_CW'(bpp_pkg::Q_DEPTH))
		else $error("queue count beyond depth");

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty queue");

	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count missed a push");

endmodule

[src/bpp_back.sv]
// ---------------------------------------------------------------------------
// bpp_back: SDNV decoder and result register
// Decodes one queued byte per cycle while the output is not stalled and holds the result for the output bus.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  bpp_pkg::item_t  q_item,
	output logic            pop,
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	output logic [79:0]     m_axis_tdata,   // [3:0] field_index, [67:4] field_value,
	                                        // [70:68] status, [78:71] bytes_used, [79] zero
	output logic            m_axis_tuser,   // [0] field_valid
	output logic            m_axis_tlast    // done_res
);

	bpp_pkg::phase_t   phase_q, phase_d;
	logic [3:0]        fn_q, fn_d;
	logic [63:0]       acc_q, acc_d;
	logic [7:0]        bc_q, bc_d;
	logic              frag_q, frag_d;
	logic              ovalid_q;
	bpp_pkg::result_t  res_q;

	logic              emit;
	bpp_pkg::result_t  res;
	logic [7:0]        bc_inc;
	logic [63:0]       acc_sh;
	logic [4:0]        next_fn;
	logic [4:0]        total;

	assign pop = q_valid && (!ovalid_q || m_axis_tready);

	// next state
	always_comb begin
		phase_d = phase_q;
		if (q_item.first) begin
			phase_d = (q_item.ver_ok && !q_item.fin) ? bpp_pkg::PH_PARSE : bpp_pkg::PH_IDLE;
		end else if (emit && res.done) begin
			phase_d = bpp_pkg::PH_IDLE;
		end
	end

	// decode outputs
	always_comb begin
		fn_d    = fn_q;
		acc_d   = acc_q;
		bc_d    = bc_q;
		frag_d  = frag_q;
		emit    = 1'b0;
		bc_inc  = (bc_q == 8'hFF) ? bc_q : bc_q + 8'd1;
		acc_sh  = {acc_q[56:0], q_item.low};
		next_fn = {1'b0, fn_q} + 5'd1;
		total   = bpp_pkg::BASE_FIELDS;
		res.idx    = fn_q;
		res.value  = '0;
		res.valid  = 1'b0;
		res.done   = 1'b0;
		res.status = bpp_pkg::ST_OK;
		res.used   = '0;

		if (q_item.first) begin
			fn_d   = '0;
			acc_d  = '0;
			frag_d = 1'b0;
			bc_d   = 8'd1;
			res.idx  = '0;
			res.used = 8'd1;
			if (!q_item.ver_ok) begin
				emit       = 1'b1;
				res.done   = 1'b1;
				res.status = bpp_pkg::ST_BADVER;
			end else if (q_item.fin) begin
				emit       = 1'b1;
				res.done   = 1'b1;
				res.status = bpp_pkg::ST_TRUNC;
			end
		end else if (phase_q == bpp_pkg::PH_PARSE) begin
			bc_d     = bc_inc;
			res.used = bc_inc;
			if (acc_q[63:57] != '0) begin
				// a set bit would leave the 64-bit value
				emit       = 1'b1;
				res.done   = 1'b1;
				res.status = bpp_pkg::ST_OVF;
			end else if (q_item.cont) begin
				acc_d = acc_sh;
				if (q_item.fin) begin
					emit       = 1'b1;
					res.done   = 1'b1;
					res.status = bpp_pkg::ST_TRUNC;
				end
			end else begin
				acc_d     = '0;
				emit      = 1'b1;
				res.valid = 1'b1;
				res.value = acc_sh;
				if (fn_q == '0) begin
					frag_d = acc_sh[0];
				end
				total = bpp_pkg::BASE_FIELDS + (frag_d ? bpp_pkg::FRAG_FIELDS : 5'd0);
				if (fn_q == 4'(bpp_pkg::BASE_FIELDS - 5'd1) && acc_sh != '0) begin
					res.done   = 1'b1;
					res.status = bpp_pkg::ST_DICT;
				end else if (next_fn >= total) begin
					res.done   = 1'b1;
					res.status = bpp_pkg::ST_OK;
				end else begin
					fn_d = next_fn[3:0];
					if (q_item.fin) begin
						res.done   = 1'b1;
						res.status = bpp_pkg::ST_TRUNC;
					end else begin
						res.used = '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= bpp_pkg::PH_IDLE;
			fn_q     <= '0;
			acc_q    <= '0;
			bc_q     <= '0;
			frag_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= phase_d;
				fn_q    <= fn_d;
				acc_q   <= acc_d;
				bc_q    <= bc_d;
				frag_q  <= frag_d;
				ovalid_q <= emit;
			end else if (m_axis_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset
	always_ff @(posedge clk) begin
		if (pop && emit) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {1'b0, res_q.used, res_q.status, res_q.value, res_q.idx};
	assign m_axis_tuser  = res_q.valid;
	assign m_axis_tlast  = res_q.done;

	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && res_q.status != bpp_pkg::ST_OK) |-> res_q.done)
		else $error("error status on a result that does not end the block");

	a_used_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && !res_q.done) |-> (res_q.used == '0))
		else $error("byte count shown before the block ends");

	a_value_only_field: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && !res_q.valid) |-> (res_q.value == '0))
		else $error("value on a result without a field");

	a_idle_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && emit && res.done) |=> (phase_q == bpp_pkg::PH_IDLE))
		else $error("parser still active after a final result");

endmodule
